[src/hsp_pkg.sv]
`timescale 1ns / 1ps
package hsp_pkg;

	localparam int PADDR_W = 5;

	typedef logic [1:0] action_t;
	localparam action_t ACT_WRITE   = 2'd0;
	localparam action_t ACT_PLAY    = 2'd1;
	localparam action_t ACT_RESTART = 2'd2;

	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_PHASE_STEP = 3'd0;
	localparam reg_idx_t REG_LOOP_START = 3'd1;
	localparam reg_idx_t REG_LOOP_END   = 3'd2;
	localparam reg_idx_t REG_LOOP_MODE  = 3'd3;
	localparam reg_idx_t REG_GAIN_LEFT  = 3'd4;
	localparam reg_idx_t REG_GAIN_RIGHT = 3'd5;

	typedef struct packed {
		logic [23:0] phase_step;
		logic [12:0] loop_start;
		logic [13:0] loop_end;
		logic        loop_mode;
		logic [15:0] gain_left;
		logic [15:0] gain_right;
	} cfg_t;

endpackage

[src/hsp_in_if.sv]
`timescale 1ns / 1ps
interface hsp_in_if import hsp_pkg::*; ();
	logic               valid;
	logic               ready;
	action_t            action;
	logic [12:0]        sample_address;
	logic signed [15:0] sample_value;

	modport source (output valid, output action, output sample_address, output sample_value,
		input ready);
	modport sink (input valid, input action, input sample_address, input sample_value,
		output ready);
endinterface

[src/hsp_out_if.sv]
`timescale 1ns / 1ps
interface hsp_out_if import hsp_pkg::*; ();
	logic               valid;
	logic               ready;
	logic signed [15:0] left_out;
	logic signed [15:0] right_out;
	logic               voice_ended;

	modport source (output valid, output left_out, output right_out, output voice_ended,
		input ready);
	modport sink (input valid, input left_out, input right_out, input voice_ended,
		output ready);
endinterface

[src/hsp_cfg_regs.sv]
`timescale 1ns / 1ps
module hsp_cfg_regs import hsp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output cfg_t               cfg
);

	logic     wr_en;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign idx    = paddr[PADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.phase_step <= 24'd65536;
			cfg.loop_start <= 13'd0;
			cfg.loop_end   <= 14'd8192;
			cfg.loop_mode  <= 1'b0;
			cfg.gain_left  <= 16'd16384;
			cfg.gain_right <= 16'd16384;
		end else if (wr_en) begin
			unique case (idx)
				REG_PHASE_STEP: cfg.phase_step <= pwdata[23:0];
				REG_LOOP_START: cfg.loop_start <= pwdata[12:0];
				REG_LOOP_END:   cfg.loop_end   <= pwdata[13:0];
				REG_LOOP_MODE:  cfg.loop_mode  <= pwdata[0];
				REG_GAIN_LEFT:  cfg.gain_left  <= pwdata[15:0];
				REG_GAIN_RIGHT: cfg.gain_right <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_PHASE_STEP: prdata = {8'd0, cfg.phase_step};
			REG_LOOP_START: prdata = {19'd0, cfg.loop_start};
			REG_LOOP_END:   prdata = {18'd0, cfg.loop_end};
			REG_LOOP_MODE:  prdata = {31'd0, cfg.loop_mode};
			REG_GAIN_LEFT:  prdata = {16'd0, cfg.gain_left};
			REG_GAIN_RIGHT: prdata = {16'd0, cfg.gain_right};
			default:        prdata = 32'd0;
		endcase
	end

endmodule

[src/hsp_wrap_div.sv]
`timescale 1ns / 1ps
// Restoring remainder, one quotient bit per cycle.
module hsp_wrap_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [14:0] dividend,
	input  logic [13:0] divisor,
	output logic        done,
	output logic [13:0] rem
);

	logic [14:0] rem_q;
	logic [14:0] dvd_q;
	logic [13:0] dsr_q;
	logic [3:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [14:0] trial;

	assign trial = {rem_q[13:0], dvd_q[14]};
	assign done  = done_q;
	assign rem   = rem_q[13:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			dvd_q  <= '0;
			dsr_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= '0;
				dvd_q  <= dividend;
				dsr_q  <= divisor;
				cnt_q  <= 4'd15;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				// subtract when the shifted partial remainder covers the divisor
				if (trial >= {1'b0, dsr_q}) begin
					rem_q <= trial - {1'b0, dsr_q};
				end else begin
					rem_q <= trial;
				end
				dvd_q <= {dvd_q[13:0], 1'b0};
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == 4'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

[src/hermite_sample_player_unit.sv]
`timescale 1ns / 1ps
// Wavetable voice with 4-point Hermite interpolation and stereo gain.
// in_ch carries requests: action 0 stores sample_value at sample_address,
// action 2 rewinds the voice, action 1 asks for one stereo result, action 3 is
// dropped. out_ch carries one result per play request (left_out, right_out,
// voice_ended). Registers sit on the APB port, one 32-bit word each.
// Writes and restarts complete on acceptance. A play request first reads the
// four neighbors through the single read port of the sample memory, then runs
// steps of one shared 24x17 multiplier and adder (three Horner terms, two
// partial products each for the wide ones, then both gains). When a looping
// voice with a non-empty loop reaches loop_end, a bit-serial remainder finds
// the wrapped position. A play request on an ended voice returns silence.
// in_ch.ready is low while a play request is in work.
// After reset a clearing pass zeroes the sample memory, one word per cycle;
// in_ch.ready stays low until it ends, and registers can
// be written meanwhile. The result register holds while out_ch.ready is low;
// writes and restarts are still taken, and a finished play result waits.
module hermite_sample_player_unit import hsp_pkg::*; #(
	parameter int SAMPLE_DEPTH = 8192
) (
	input  logic               clk,
	input  logic               arst_n,
	hsp_in_if.sink             in_ch,
	hsp_out_if.source          out_ch,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int AW = $clog2(SAMPLE_DEPTH);
	localparam logic [16:0] DEPTH17 = 17'(SAMPLE_DEPTH);

	typedef enum logic [4:0] {
		S_IDLE, S_RD, S_COEF, S_M1, S_H1, S_M2L, S_M2H, S_H2,
		S_M3L, S_M3H, S_H3, S_SAT, S_GL, S_GR, S_ADV, S_DIV, S_DONE
	} state_t;

	function automatic logic signed [15:0] sat16(input logic signed [23:0] x);
		if (x > 24'sd32767) begin
			return 16'sh7fff;
		end else if (x < -24'sd32768) begin
			return -16'sh8000;
		end
		return 16'(x);
	endfunction

	cfg_t cfg;

	hsp_cfg_regs u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	state_t             state_q;
	logic               clr_busy_q;
	logic [AW-1:0]      clr_idx_q;
	logic [13:0]        pos_q;
	logic [15:0]        frac_q;
	logic               ended_q;
	logic [2:0]         rd_cnt_q;
	logic               rd_ok_q;
	logic signed [15:0] x_q [4];
	logic signed [19:0] a_q;
	logic signed [20:0] b_q;
	logic signed [16:0] c_q;
	logic signed [40:0] prod_q;
	logic [15:0]        lo_q;
	logic signed [37:0] h_q;
	logic signed [15:0] s_q;
	logic signed [15:0] res_l_q;
	logic signed [15:0] res_r_q;
	logic               out_valid_q;
	logic signed [15:0] out_l_q;
	logic signed [15:0] out_r_q;
	logic               out_end_q;

	logic [15:0]        mem_q [SAMPLE_DEPTH];
	logic [15:0]        rd_q;
	logic               mem_we;
	logic [AW-1:0]      mem_wa;
	logic [15:0]        mem_wd;
	logic [AW-1:0]      mem_ra;

	logic               in_acc;
	logic [16:0]        wr_ext;
	logic [14:0]        rd_pos;
	logic [16:0]        rd_ext;
	logic               rd_ok;

	logic signed [23:0] mul_a;
	logic signed [16:0] mul_b;
	logic signed [40:0] mul_p;

	logic signed [20:0] cf_c, cf_v, cf_w, cf_a, cf_b;
	logic signed [38:0] h_round;
	logic signed [41:0] g_round;

	logic [24:0]        sum;
	logic [14:0]        pos_sum;
	logic [14:0]        div_dvd;
	logic [13:0]        div_dsr;
	logic               loop_empty;
	logic               div_start;
	logic               div_done;
	logic [13:0]        div_rem;
	logic               out_free;

	assign in_ch.ready  = (state_q == S_IDLE) && !clr_busy_q;
	assign in_acc       = in_ch.valid && in_ch.ready;
	assign out_ch.valid       = out_valid_q;
	assign out_ch.left_out    = out_l_q;
	assign out_ch.right_out   = out_r_q;
	assign out_ch.voice_ended = out_end_q;
	assign out_free     = !out_valid_q || out_ch.ready;

	// memory: clearing pass has the write port until it ends
	assign wr_ext = 17'(in_ch.sample_address);
	assign mem_we = clr_busy_q ||
		(in_acc && in_ch.action == ACT_WRITE && wr_ext < DEPTH17);
	assign mem_wa = clr_busy_q ? clr_idx_q : wr_ext[AW-1:0];
	assign mem_wd = clr_busy_q ? 16'd0 : in_ch.sample_value;

	// neighbor p-1+k for read slot k
	assign rd_pos = 15'(pos_q) + 15'(rd_cnt_q) - 15'd1;
	assign rd_ext = 17'(rd_pos);
	assign mem_ra = rd_ext[AW-1:0];
	assign rd_ok  = (rd_cnt_q < 3'd4) && !(rd_cnt_q == 3'd0 && pos_q == 14'd0) &&
		(rd_ext < DEPTH17);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		rd_q <= mem_q[mem_ra];
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_M1: begin
				mul_a = 24'(a_q);
				mul_b = $signed({1'b0, frac_q});
			end
			S_M2L, S_M3L: begin
				mul_a = $signed({8'd0, h_q[15:0]});
				mul_b = $signed({1'b0, frac_q});
			end
			S_M2H, S_M3H: begin
				mul_a = 24'($signed(h_q[37:16]));
				mul_b = $signed({1'b0, frac_q});
			end
			S_GL: begin
				mul_a = 24'(s_q);
				mul_b = $signed({1'b0, cfg.gain_left});
			end
			S_GR: begin
				mul_a = 24'(s_q);
				mul_b = $signed({1'b0, cfg.gain_right});
			end
			default: ;
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Hermite terms in half units
	assign cf_c = 21'(x_q[2]) - 21'(x_q[0]);
	assign cf_v = (21'(x_q[1]) - 21'(x_q[2])) <<< 1;
	assign cf_w = cf_c + cf_v;
	assign cf_a = cf_w + cf_v + 21'(x_q[3]) - 21'(x_q[1]);
	assign cf_b = cf_w + cf_a;

	assign h_round = 39'(h_q) + 39'sd65536;
	assign g_round = 42'(prod_q) + 42'sd8192;

	// phase advance and loop handling
	assign sum        = {9'd0, frac_q} + {1'b0, cfg.phase_step};
	assign pos_sum    = 15'(pos_q) + 15'(sum[24:16]);
	assign loop_empty = cfg.loop_end <= {1'b0, cfg.loop_start};
	assign div_dvd    = pos_sum - 15'(cfg.loop_start);
	assign div_dsr    = cfg.loop_end - 14'(cfg.loop_start);
	assign div_start  = (state_q == S_ADV) && (pos_sum >= 15'(cfg.loop_end)) &&
		cfg.loop_mode && !loop_empty;

	hsp_wrap_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_dvd),
		.divisor(div_dsr), .done(div_done), .rem(div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			clr_busy_q  <= 1'b1;
			clr_idx_q   <= '0;
			pos_q       <= '0;
			frac_q      <= '0;
			ended_q     <= 1'b0;
			rd_cnt_q    <= '0;
			rd_ok_q     <= 1'b0;
			x_q         <= '{default: '0};
			a_q         <= '0;
			b_q         <= '0;
			c_q         <= '0;
			prod_q      <= '0;
			lo_q        <= '0;
			h_q         <= '0;
			s_q         <= '0;
			res_l_q     <= '0;
			res_r_q     <= '0;
			out_valid_q <= 1'b0;
			out_l_q     <= '0;
			out_r_q     <= '0;
			out_end_q   <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == AW'(SAMPLE_DEPTH - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			prod_q <= mul_p;
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						unique case (in_ch.action)
							ACT_RESTART: begin
								pos_q   <= '0;
								frac_q  <= '0;
								ended_q <= 1'b0;
							end
							ACT_PLAY: begin
								if (ended_q) begin
									res_l_q <= '0;
									res_r_q <= '0;
									state_q <= S_DONE;
								end else begin
									rd_cnt_q <= '0;
									state_q  <= S_RD;
								end
							end
							default: ;
						endcase
					end
				end
				S_RD: begin
					rd_ok_q  <= rd_ok;
					rd_cnt_q <= rd_cnt_q + 3'd1;
					if (rd_cnt_q != 3'd0) begin
						x_q[2'(rd_cnt_q - 3'd1)] <= rd_ok_q ? $signed(rd_q) : 16'sd0;
					end
					if (rd_cnt_q == 3'd4) begin
						state_q <= S_COEF;
					end
				end
				S_COEF: begin
					a_q     <= 20'(cf_a);
					b_q     <= cf_b;
					c_q     <= 17'(cf_c);
					state_q <= S_M1;
				end
				S_M1: state_q <= S_H1;
				S_H1: begin
					h_q     <= 38'(prod_q - (41'(b_q) <<< 16));
					state_q <= S_M2L;
				end
				S_M2L: state_q <= S_M2H;
				S_M2H: begin
					lo_q    <= prod_q[31:16];
					state_q <= S_H2;
				end
				S_H2: begin
					// floor(h*t >> 16) = hi*t + (lo*t >> 16), lo being non-negative
					h_q     <= 38'(prod_q + $signed({25'd0, lo_q}) + (41'(c_q) <<< 16));
					state_q <= S_M3L;
				end
				S_M3L: state_q <= S_M3H;
				S_M3H: begin
					lo_q    <= prod_q[31:16];
					state_q <= S_H3;
				end
				S_H3: begin
					h_q     <= 38'(prod_q + $signed({25'd0, lo_q}) + (41'(x_q[1]) <<< 17));
					state_q <= S_SAT;
				end
				S_SAT: begin
					s_q     <= sat16(24'(h_round >>> 17));
					state_q <= S_GL;
				end
				S_GL: state_q <= S_GR;
				S_GR: begin
					res_l_q <= sat16(24'(g_round >>> 14));
					state_q <= S_ADV;
				end
				S_ADV: begin
					res_r_q <= sat16(24'(g_round >>> 14));
					frac_q  <= sum[15:0];
					state_q <= S_DONE;
					if (pos_sum >= 15'(cfg.loop_end)) begin
						if (!cfg.loop_mode) begin
							ended_q <= 1'b1;
							pos_q   <= pos_sum[14] ? 14'h3fff : pos_sum[13:0];
						end else if (loop_empty) begin
							pos_q <= 14'(cfg.loop_start);
						end else begin
							state_q <= S_DIV;
						end
					end else begin
						pos_q <= pos_sum[13:0];
					end
				end
				S_DIV: begin
					if (div_done) begin
						pos_q   <= 14'(cfg.loop_start) + div_rem;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					// hold the result until the output register frees up
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_l_q     <= res_l_q;
						out_r_q     <= res_r_q;
						out_end_q   <= ended_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !in_acc)
		else $error("request accepted during memory clearing pass");

	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("remainder finished outside the wrap wait");

	a_wrap_below_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && div_done) |=> pos_q < cfg.loop_end)
		else $error("wrapped position not below loop end");

	a_ended_result_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && in_acc && in_ch.action == ACT_PLAY && ended_q)
		|=> res_l_q == 16'sd0 && res_r_q == 16'sd0 && state_q == S_DONE)
		else $error("ended voice did not produce a silent result");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
module testbench;
	import hsp_pkg::*;

	localparam int SAMPLE_DEPTH = 8192;
	localparam int STALL_LIMIT = 50000;
	localparam int SETTLE_CYCLES = 40;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_REQUESTS = 250;
	localparam action_t ACT_UNUSED = 2'd3;

	typedef struct packed {
		logic signed [15:0] left;
		logic signed [15:0] right;
		logic               ended;
	} stereo_t;

	typedef struct packed {
		logic        is_reg;
		action_t     action;
		logic [12:0] address;
		logic [15:0] value;
		reg_idx_t    ridx;
		logic [31:0] rval;
		logic        known;
		stereo_t     want;
	} row_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	hsp_in_if  in_ch();
	hsp_out_if out_ch();

	hermite_sample_player_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// voice predictor state and register copy
	logic signed [15:0] sample_mem [SAMPLE_DEPTH];
	int unsigned        voice_pos;
	int unsigned        voice_frac;
	bit                 voice_done;
	int unsigned        step_cfg;
	int unsigned        loop_lo;
	int unsigned        loop_hi;
	int unsigned        loop_wrap;
	int unsigned        gain_l;
	int unsigned        gain_r;

	stereo_t stereo_due[$];
	int      mismatches;
	int      results_seen;
	int      requests_sent;
	int      settings_used;
	int      idle_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint clamp16(longint x);
		if (x > 32767)
			return 32767;
		if (x < -32768)
			return -32768;
		return x;
	endfunction

	// positions outside the store, including the one before position 0, read as zero
	function automatic longint word_at(longint pos);
		if (pos < 0 || pos >= SAMPLE_DEPTH)
			return 0;
		return longint'(sample_mem[pos]);
	endfunction

	function automatic longint hermite_at_cursor();
		longint p, t, xm1, x0, x1, x2, c, v, w, a, b, h;
		p = voice_pos;
		t = voice_frac;
		xm1 = word_at(p - 1);
		x0 = word_at(p);
		x1 = word_at(p + 1);
		x2 = word_at(p + 2);
		c = x1 - xm1;
		v = 2 * (x0 - x1);
		w = c + v;
		a = w + v + x2 - x0;
		b = w + a;
		// Horner in Q16 half units, each product floored
		h = a * t - b * 65536;
		h = ((h * t) >>> 16) + c * 65536;
		h = ((h * t) >>> 16) + 2 * x0 * 65536;
		return clamp16((h + 65536) >>> 17);
	endfunction

	function automatic logic signed [15:0] scale_gain(longint s, int unsigned g);
		longint gw;
		gw = g;
		return 16'(clamp16((s * gw + 8192) >>> 14));
	endfunction

	function automatic void run_voice_request(action_t act, logic [12:0] addr,
		logic [15:0] value, output bit has_frame, output stereo_t frame);
		longint      s;
		int unsigned acc;
		int unsigned pos;
		has_frame = 1'b0;
		frame = '0;
		case (act)
			ACT_WRITE: sample_mem[addr] = value;
			ACT_RESTART: begin
				voice_pos = 0;
				voice_frac = 0;
				voice_done = 1'b0;
			end
			ACT_PLAY: begin
				has_frame = 1'b1;
				if (voice_done) begin
					frame.ended = 1'b1;
				end else begin
					s = hermite_at_cursor();
					frame.left = scale_gain(s, gain_l);
					frame.right = scale_gain(s, gain_r);
					acc = voice_frac + step_cfg;
					pos = voice_pos + (acc >> 16);
					voice_frac = acc & 32'hFFFF;
					if (pos >= loop_hi) begin
						if (loop_wrap == 0) begin
							voice_done = 1'b1;
							if (pos > 16383)
								pos = 16383;
						end else if (loop_hi <= loop_lo) begin
							pos = loop_lo;
						end else begin
							pos = loop_lo + (pos - loop_lo) % (loop_hi - loop_lo);
						end
					end
					voice_pos = pos;
					frame.ended = voice_done;
				end
			end
			default: ;
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(20, 60);
	endfunction

	function automatic void flag_mismatch(string msg);
		if (mismatches < 10)
			$display("%s", msg);
		mismatches++;
	endfunction

	function automatic row_t req(action_t act, logic [12:0] addr, logic [15:0] value);
		row_t row;
		row = '0;
		row.action = act;
		row.address = addr;
		row.value = value;
		return row;
	endfunction

	function automatic row_t play_is(logic signed [15:0] l, logic signed [15:0] rt, logic e);
		row_t row;
		row = req(ACT_PLAY, '0, '0);
		row.known = 1'b1;
		row.want.left = l;
		row.want.right = rt;
		row.want.ended = e;
		return row;
	endfunction

	function automatic row_t set_reg(reg_idx_t idx, logic [31:0] value);
		row_t row;
		row = '0;
		row.is_reg = 1'b1;
		row.ridx = idx;
		row.rval = value;
		return row;
	endfunction

	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_PHASE_STEP: step_cfg = value & 32'hFF_FFFF;
			REG_LOOP_START: loop_lo = value & 32'h1FFF;
			REG_LOOP_END:   loop_hi = value & 32'h3FFF;
			REG_LOOP_MODE:  loop_wrap = value & 32'h1;
			REG_GAIN_LEFT:  gain_l = value & 32'hFFFF;
			REG_GAIN_RIGHT: gain_r = value & 32'hFFFF;
			default: ;
		endcase
	endtask

	task automatic push_request(action_t act, logic [12:0] addr, logic [15:0] value,
		bit known, stereo_t want);
		bit      has_frame;
		stereo_t frame;
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.action <= act;
		in_ch.sample_address <= addr;
		in_ch.sample_value <= value;
		do @(posedge clk); while (!in_ch.ready);
		run_voice_request(act, addr, value, has_frame, frame);
		if (has_frame)
			stereo_due.push_back(known ? want : frame);
		requests_sent++;
	endtask

	task automatic hold_off(int n);
		if (n > 0) begin
			@(negedge clk);
			in_ch.valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// wait for every result, then let writes and restarts in flight settle
	task automatic drain();
		hold_off(1);
		while (stereo_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_phase(int ph);
		int unsigned st, lo, hi, md, gl, gr;
		st = $urandom_range(0, 32'h3FFFF);
		lo = $urandom_range(0, 200);
		hi = $urandom_range(lo + 1, 600);
		md = $urandom_range(0, 1);
		gl = $urandom_range(0, 32768);
		gr = $urandom_range(0, 32768);
		case (ph)
			1: begin
				st = 0;
				lo = 0;
				hi = 1;
				md = 1;
				gl = 32768;
				gr = 32768;
			end
			2: begin
				st = 32'hFF_FFFF;
				lo = 0;
				hi = 8192;
				md = 1;
				gl = 0;
				gr = 65535;
			end
			3: begin
				st = $urandom_range(32'h40_0000, 32'hFF_FFFF);
				lo = 8191;
				hi = 8192;
				md = 1;
			end
			4: begin
				st = 32'h1_0000;
				lo = 0;
				hi = 1;
				md = 0;
			end
			5: begin
				// inverted loop
				lo = $urandom_range(100, 8191);
				hi = $urandom_range(1, lo);
				md = 1;
			end
			6: begin
				st = $urandom_range(32'h10_0000, 32'hFF_FFFF);
				lo = 0;
				hi = 8192;
				md = 0;
			end
			7: begin
				st = $urandom_range(0, 32'hFF_FFFF);
				lo = $urandom_range(0, 8191);
				hi = $urandom_range(1, 8192);
				gl = $urandom_range(0, 65535);
				gr = $urandom_range(0, 65535);
			end
			default: ;
		endcase
		write_reg(REG_PHASE_STEP, st);
		write_reg(REG_LOOP_START, lo);
		write_reg(REG_LOOP_END, hi);
		write_reg(REG_LOOP_MODE, md);
		write_reg(REG_GAIN_LEFT, gl);
		write_reg(REG_GAIN_RIGHT, gr);
		settings_used++;
	endtask

	// receiver: bursts of ready, sometimes long, separated by random stalls
	initial begin
		int stall;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ch.ready <= 1'b1;
			repeat (($urandom_range(0, 3) == 0) ? $urandom_range(50, 300)
				: $urandom_range(1, 8)) @(negedge clk);
			stall = pick_gap();
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		stereo_t want;
		stereo_t got;
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
			|| (psel && penable && pwrite && pready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.left = out_ch.left_out;
			got.right = out_ch.right_out;
			got.ended = out_ch.voice_ended;
			results_seen++;
			if (stereo_due.size() == 0) begin
				flag_mismatch($sformatf("unexpected result at %0t: left %0d right %0d ended %0b",
					$realtime, got.left, got.right, got.ended));
			end else begin
				want = stereo_due.pop_front();
				if (got.left !== want.left || got.right !== want.right
					|| got.ended !== want.ended)
					flag_mismatch($sformatf(
						"result %0d at %0t: expected %0d/%0d/%0b, got %0d/%0d/%0b",
						results_seen, $realtime, want.left, want.right, want.ended,
						got.left, got.right, got.ended));
			end
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		row_t        directed[$];
		action_t     act;
		logic [12:0] addr;
		logic [15:0] value;
		bit          calm;
		int          r;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.action = ACT_WRITE;
		in_ch.sample_address = '0;
		in_ch.sample_value = '0;
		foreach (sample_mem[i])
			sample_mem[i] = '0;
		voice_pos = 0;
		voice_frac = 0;
		voice_done = 1'b0;
		step_cfg = 32'h1_0000;
		loop_lo = 0;
		loop_hi = 8192;
		loop_wrap = 0;
		gain_l = 16384;
		gain_r = 16384;
		mismatches = 0;
		results_seen = 0;
		requests_sent = 0;
		settings_used = 0;
		idle_cycles = 0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		directed = '{
			// store cleared after reset, no neighbor before position 0
			play_is(16'sd0, 16'sd0, 1'b0),
			req(ACT_WRITE, 13'd0, 16'h7FFF),
			req(ACT_WRITE, 13'd1, 16'h8000),
			req(ACT_WRITE, 13'h1FFF, 16'hFFFF),
			req(ACT_WRITE, 13'd2, 16'h5A5A),
			req(ACT_RESTART, 13'd0, 16'h0000),
			play_is(16'sd32767, 16'sd32767, 1'b0),
			play_is(-16'sd32768, -16'sd32768, 1'b0),
			req(ACT_UNUSED, 13'h1555, 16'hAAAA),
			set_reg(REG_PHASE_STEP, 32'h8000),
			req(ACT_PLAY, 13'd0, 16'h0000),
			req(ACT_PLAY, 13'd0, 16'h0000),
			// gain above 2.0 saturates, zero gain silences
			set_reg(REG_GAIN_LEFT, 32'hFFFF),
			set_reg(REG_GAIN_RIGHT, 32'h0),
			req(ACT_RESTART, 13'd0, 16'h0000),
			play_is(16'sd32767, 16'sd0, 1'b0),
			req(ACT_PLAY, 13'd0, 16'h0000),
			set_reg(REG_PHASE_STEP, 32'hFF_FFFF),
			set_reg(REG_LOOP_END, 32'd300),
			req(ACT_PLAY, 13'd0, 16'h0000),
			req(ACT_PLAY, 13'd0, 16'h0000),
			play_is(16'sd0, 16'sd0, 1'b1),
			// looping: wrap back into the loop, then an inverted loop
			set_reg(REG_LOOP_MODE, 32'd1),
			set_reg(REG_LOOP_START, 32'd100),
			req(ACT_RESTART, 13'd0, 16'h0000),
			req(ACT_PLAY, 13'd0, 16'h0000),
			req(ACT_PLAY, 13'd0, 16'h0000),
			set_reg(REG_LOOP_START, 32'd5000),
			req(ACT_PLAY, 13'd0, 16'h0000),
			req(ACT_PLAY, 13'd0, 16'h0000)
		};

		foreach (directed[i]) begin
			if (directed[i].is_reg) begin
				drain();
				write_reg(directed[i].ridx, directed[i].rval);
			end else begin
				push_request(directed[i].action, directed[i].address, directed[i].value,
					directed[i].known, directed[i].want);
			end
		end

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			drain();
			set_phase(ph);
			calm = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < PHASE_REQUESTS; n++) begin
				r = $urandom_range(0, 99);
				if (r < 58)
					act = ACT_PLAY;
				else if (r < 80)
					act = ACT_WRITE;
				else if (r < 95)
					act = ACT_RESTART;
				else
					act = ACT_UNUSED;
				// half the writes land around the play cursor
				if ($urandom_range(0, 1) == 1)
					addr = 13'($urandom_range(0, 8191));
				else
					addr = 13'(voice_pos + $urandom_range(0, 4) - 1);
				case ($urandom_range(0, 9))
					0: value = 16'h7FFF;
					1: value = 16'h8000;
					default: value = 16'($urandom());
				endcase
				push_request(act, addr, value, 1'b0, '0);
				if ($urandom_range(0, 199) == 0)
					drain();
				else
					hold_off(calm ? 0 : pick_gap());
			end
		end

		hold_off(1);
		while (stereo_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d requests (writes, restarts, plays, unused) across %0d settings.",
			requests_sent, settings_used);
		$display("Checked %0d stereo results, %0d mismatches.", results_seen, mismatches);
		if (mismatches == 0 && stereo_due.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[hermite_sample_player_unit.f]
src/hsp_pkg.sv
src/hsp_in_if.sv
src/hsp_out_if.sv
src/hsp_cfg_regs.sv
src/hsp_wrap_div.sv
src/hermite_sample_player_unit.sv
tb/testbench.sv
